[hdl/hca_pkg.sv]
// Shared types and constants of the HMM count accumulator.
// Command and result kind codes and the fixed start and end states; no dependencies.
package hca_pkg;

    // Width of the Q8.8 weight field
    localparam int WEIGHT_BITS = 16;

    // Request command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Result kind codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TRANS = 2'd0;
    localparam t_kind KIND_EMIT  = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;

    // Silent start and end states of every sequence
    localparam int START_ST = 0;
    localparam int END_ST   = 1;

endpackage

[hdl/hca_count_ram.sv]
// Single-port-write, single-port-read count memory with a registered read.
// Generic storage for the accumulator; no package dependency.
module hca_count_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: hold the last read word until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/hca_sat_add.sv]
// Saturating adder of a Q8.8 weight onto an unsigned fixed-point count.
// Uses hca_pkg::WEIGHT_BITS.
module hca_sat_add #(
    parameter int COUNT_BITS = 32
) (
    input  logic [COUNT_BITS-1:0]           i_count,
    input  logic [hca_pkg::WEIGHT_BITS-1:0] i_weight,
    output logic [COUNT_BITS-1:0]           o_sum
);

    logic [COUNT_BITS:0] w_sum;

    // Add with a carry bit, clamp to all ones on overflow
    assign w_sum = {1'b0, i_count} + (COUNT_BITS+1)'(i_weight);
    assign o_sum = w_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : w_sum[COUNT_BITS-1:0];

endmodule

[hdl/hmm_count_accumulator.sv]
// HMM transition and emission count accumulator, top level.
// Depends on hca_pkg, hca_count_ram and hca_sat_add.
//
// Input channel (i_valid / o_ready) takes one request per sequence position:
// symbol, label, Q8.8 weight and first/last marks, or a clear command.
// Output channel (o_valid / i_ready) returns each updated count: the incoming
// transition, the emission, and on a last position the transition to the end
// state; final_result marks the last of them. A clear returns one result of
// kind "clear finished" once both stores are zero.
// An accumulate request is taken in S_IDLE, which starts the registered read
// of both memories; S_T1E, S_E and, on a last position, S_T2 then each load a
// result into the output register, one per cycle when the receiver keeps up.
// The output register, one result wide, sets this pace.
// The block takes a new request only after all results of the previous one
// have been loaded into the output register.
// Reset and the clear command run a clearing pass that writes zero to one entry
// of each memory per cycle; its counter sweeps 2**max(2*log2(LABEL_COUNT),
// log2(ALPHABET)+log2(LABEL_COUNT)) values, 4096 at the default sizes.
// o_ready stays low during the pass. A stalled receiver holds the output
// register and the sequencer waits; no result is lost or dropped.
module hmm_count_accumulator #(
    parameter int LABEL_COUNT = 64,
    parameter int ALPHABET    = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic [4:0]                      i_symbol,
    input  logic [5:0]                      i_label,
    input  logic [hca_pkg::WEIGHT_BITS-1:0] i_weight,
    input  logic                            i_first_pos,
    input  logic                            i_last_pos,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic [5:0]                      o_row_index,
    output logic [5:0]                      o_col_index,
    output logic [31:0]                     o_count_value,
    output logic                            o_final_result
);

    localparam int SW   = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
    localparam int AW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TAW  = 2 * SW;
    localparam int EAW  = AW + SW;
    localparam int CLW  = (TAW > EAW) ? TAW : EAW;
    localparam int XSW  = (SW > 6) ? SW : 6;
    localparam int XAW  = (AW > 6) ? AW : 6;
    localparam int OXW  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam logic [SW-1:0] START_SW = SW'(hca_pkg::START_ST);
    localparam logic [SW-1:0] END_SW   = SW'(hca_pkg::END_ST);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_CLR_DONE,
        S_IDLE,
        S_T1E,
        S_E,
        S_T2
    } t_state;

    t_state r_state, n_state;

    logic [CLW-1:0]        r_clr_cnt, n_clr_cnt;
    logic                  r_clr_cmd, n_clr_cmd;
    logic [SW-1:0]         r_prev, n_prev;
    logic [SW-1:0]         r_from, n_from;
    logic [SW-1:0]         r_lab, n_lab;
    logic [AW-1:0]         r_sym, n_sym;
    logic [hca_pkg::WEIGHT_BITS-1:0] r_w, n_w;
    logic                  r_last, n_last;
    logic                  r_fwd, n_fwd;
    logic [COUNT_BITS-1:0] r_t1val, n_t1val;
    logic [COUNT_BITS-1:0] r_eval, n_eval;

    logic                  r_ov, n_ov;
    hca_pkg::t_kind        r_kind, n_kind;
    logic [5:0]            r_row, n_row;
    logic [5:0]            r_col, n_col;
    logic [COUNT_BITS-1:0] r_val, n_val;
    logic                  r_fin, n_fin;

    logic w_accept;
    logic w_out_free;
    logic w_is_clear;

    // Index reduction tables: label mod LABEL_COUNT, symbol mod ALPHABET
    logic [SW-1:0] w_lab_tab [64];
    logic [AW-1:0] w_sym_tab [32];

    for (genvar g = 0; g < 64; g++) begin : g_lab_tab
        assign w_lab_tab[g] = SW'(g % LABEL_COUNT);
    end
    for (genvar g = 0; g < 32; g++) begin : g_sym_tab
        assign w_sym_tab[g] = AW'(g % ALPHABET);
    end

    logic [SW-1:0] w_lab_in;
    logic [AW-1:0] w_sym_in;
    logic [SW-1:0] w_from_in;

    assign w_lab_in  = w_lab_tab[i_label];
    assign w_sym_in  = w_sym_tab[i_symbol];
    assign w_from_in = i_first_pos ? START_SW : r_prev;

    // Reported indices, masked to six bits
    logic [XSW-1:0] w_from_x;
    logic [XSW-1:0] w_lab_x;
    logic [XAW-1:0] w_sym_x;

    assign w_from_x = XSW'(r_from);
    assign w_lab_x  = XSW'(r_lab);
    assign w_sym_x  = XAW'(r_sym);

    // Memory ports
    logic                  w_t_rd_en, w_t_we;
    logic [TAW-1:0]        w_t_rd_addr, w_t_wr_addr;
    logic [COUNT_BITS-1:0] w_t_rd_data, w_t_wr_data;
    logic                  w_e_rd_en, w_e_we;
    logic [EAW-1:0]        w_e_rd_addr, w_e_wr_addr;
    logic [COUNT_BITS-1:0] w_e_rd_data, w_e_wr_data;

    logic [COUNT_BITS-1:0] w_t1_sum, w_e_sum, w_t2_sum, w_t2_base;

    hca_count_ram #(
        .ADDR_BITS (TAW),
        .DATA_BITS (COUNT_BITS)
    ) u_trans_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_t_rd_en),
        .i_rd_addr (w_t_rd_addr),
        .o_rd_data (w_t_rd_data),
        .i_wr_en   (w_t_we),
        .i_wr_addr (w_t_wr_addr),
        .i_wr_data (w_t_wr_data)
    );

    hca_count_ram #(
        .ADDR_BITS (EAW),
        .DATA_BITS (COUNT_BITS)
    ) u_emit_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_e_rd_en),
        .i_rd_addr (w_e_rd_addr),
        .o_rd_data (w_e_rd_data),
        .i_wr_en   (w_e_we),
        .i_wr_addr (w_e_wr_addr),
        .i_wr_data (w_e_wr_data)
    );

    // Forward the incoming transition when the end transition hits the same cell
    assign w_t2_base = r_fwd ? r_t1val : w_t_rd_data;

    hca_sat_add #(.COUNT_BITS(COUNT_BITS)) u_add_t1 (
        .i_count  (w_t_rd_data),
        .i_weight (r_w),
        .o_sum    (w_t1_sum)
    );

    hca_sat_add #(.COUNT_BITS(COUNT_BITS)) u_add_e (
        .i_count  (w_e_rd_data),
        .i_weight (r_w),
        .o_sum    (w_e_sum)
    );

    hca_sat_add #(.COUNT_BITS(COUNT_BITS)) u_add_t2 (
        .i_count  (w_t2_base),
        .i_weight (r_w),
        .o_sum    (w_t2_sum)
    );

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ov || i_ready;
    assign w_is_clear = (i_cmd == hca_pkg::CMD_CLEAR);

    // Drive memory reads: both counts on a request, end transition after it
    always_comb begin
        w_t_rd_en   = (w_accept && !w_is_clear)
                   || (r_state == S_T1E && w_out_free && r_last);
        w_t_rd_addr = (r_state == S_IDLE) ? {w_from_in, w_lab_in} : {r_lab, END_SW};
        w_e_rd_en   = w_accept && !w_is_clear;
        w_e_rd_addr = {w_sym_in, w_lab_in};
    end

    // Drive memory writes: clearing pass or write-back of updated counts
    always_comb begin
        w_t_we      = 1'b0;
        w_t_wr_addr = r_clr_cnt[TAW-1:0];
        w_t_wr_data = '0;
        w_e_we      = 1'b0;
        w_e_wr_addr = r_clr_cnt[EAW-1:0];
        w_e_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                w_t_we = 1'b1;
                w_e_we = 1'b1;
            end
            S_T1E: begin
                w_t_we      = w_out_free;
                w_t_wr_addr = {r_from, r_lab};
                w_t_wr_data = w_t1_sum;
                w_e_we      = w_out_free;
                w_e_wr_addr = {r_sym, r_lab};
                w_e_wr_data = w_e_sum;
            end
            S_T2: begin
                w_t_we      = w_out_free;
                w_t_wr_addr = {r_lab, END_SW};
                w_t_wr_data = w_t2_sum;
            end
            default: begin
            end
        endcase
    end

    // Sequencer: next state, request capture and result loading
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_clr_cmd = r_clr_cmd;
        n_prev    = r_prev;
        n_from    = r_from;
        n_lab     = r_lab;
        n_sym     = r_sym;
        n_w       = r_w;
        n_last    = r_last;
        n_fwd     = r_fwd;
        n_t1val   = r_t1val;
        n_eval    = r_eval;
        n_ov      = r_ov && !i_ready;
        n_kind    = r_kind;
        n_row     = r_row;
        n_col     = r_col;
        n_val     = r_val;
        n_fin     = r_fin;
        case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    n_state = r_clr_cmd ? S_CLR_DONE : S_IDLE;
                end
            end
            S_CLR_DONE: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_kind    = hca_pkg::KIND_CLEAR;
                    n_row     = '0;
                    n_col     = '0;
                    n_val     = '0;
                    n_fin     = 1'b1;
                    n_clr_cmd = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_clear) begin
                        n_clr_cmd = 1'b1;
                        n_clr_cnt = '0;
                        n_prev    = START_SW;
                        n_state   = S_CLEAR;
                    end else begin
                        n_from  = w_from_in;
                        n_lab   = w_lab_in;
                        n_sym   = w_sym_in;
                        n_w     = i_weight;
                        n_last  = i_last_pos;
                        n_prev  = w_lab_in;
                        n_state = S_T1E;
                    end
                end
            end
            S_T1E: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = hca_pkg::KIND_TRANS;
                    n_row   = w_from_x[5:0];
                    n_col   = w_lab_x[5:0];
                    n_val   = w_t1_sum;
                    n_fin   = 1'b0;
                    n_t1val = w_t1_sum;
                    n_eval  = w_e_sum;
                    n_fwd   = (r_from == r_lab) && (r_lab == END_SW);
                    n_state = S_E;
                end
            end
            S_E: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = hca_pkg::KIND_EMIT;
                    n_row   = w_sym_x[5:0];
                    n_col   = w_lab_x[5:0];
                    n_val   = r_eval;
                    n_fin   = !r_last;
                    n_state = r_last ? S_T2 : S_IDLE;
                end
            end
            S_T2: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = hca_pkg::KIND_TRANS;
                    n_row   = w_lab_x[5:0];
                    n_col   = 6'(hca_pkg::END_ST);
                    n_val   = w_t2_sum;
                    n_fin   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, request registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_clr_cmd <= 1'b0;
            r_prev    <= START_SW;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_clr_cmd <= n_clr_cmd;
            r_prev    <= n_prev;
            r_ov      <= n_ov;
        end
        r_from  <= n_from;
        r_lab   <= n_lab;
        r_sym   <= n_sym;
        r_w     <= n_w;
        r_last  <= n_last;
        r_fwd   <= n_fwd;
        r_t1val <= n_t1val;
        r_eval  <= n_eval;
        r_kind  <= n_kind;
        r_row   <= n_row;
        r_col   <= n_col;
        r_val   <= n_val;
        r_fin   <= n_fin;
    end

    logic [OXW-1:0] w_val_x;
    assign w_val_x = OXW'(r_val);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_row_index    = r_row;
    assign o_col_index    = r_col;
    assign o_count_value  = w_val_x[31:0];
    assign o_final_result = r_fin;

    // An accepted accumulate request moves straight to the count update
    a_accum_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_cmd == hca_pkg::CMD_ACCUM) |=> (r_state == S_T1E))
        else $error("accumulate request did not start the count update");

    // A clear result is always final and carries a zero count and row index
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == hca_pkg::KIND_CLEAR)
            |-> (o_final_result && o_count_value == '0 && o_row_index == '0))
        else $error("clear result carries data or is not final");

    // A written-back incoming-transition or emission count never falls below the count that was read
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T1E && w_out_free)
            |-> (w_t1_sum >= w_t_rd_data && w_e_sum >= w_e_rd_data))
        else $error("updated count below stored count");

endmodule

[bench/hca_count_checker.sv]
// Scoreboard for the HMM count accumulator: watches both channels, keeps its
// own transition and emission counts, and compares every returned count update.
// Depends on hca_pkg for the command and result codes and the start and end states.
module hca_count_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel, as seen at the block
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_cmd,
    input  logic [4:0]  i_symbol,
    input  logic [5:0]  i_label,
    input  logic [15:0] i_weight,
    input  logic        i_first_pos,
    input  logic        i_last_pos,
    // result channel, as seen at the block
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_row_index,
    input  logic [5:0]  i_col_index,
    input  logic [31:0] i_count_value,
    input  logic        i_final_result,
    // status for the testbench top
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        hca_pkg::t_kind kind;
        logic [5:0]     row;
        logic [5:0]     col;
        logic [31:0]    count;
        logic           fin;
    } t_count_update;

    // Shadow count stores, indexed {from, to} and {symbol, label}
    logic [31:0]   trans_counts [0:4095];
    logic [31:0]   emit_counts  [0:2047];
    logic [5:0]    prev_label;
    t_count_update upcoming_updates [$];
    int            err_cnt;
    int            checked_cnt;

    // Add a Q8.8 weight to a Q24.8 count, pinned at the maximum
    function automatic logic [31:0] sat_sum(logic [31:0] cur, logic [15:0] w);
        logic [32:0] s;
        s = {1'b0, cur} + {17'd0, w};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic zero_shadow_counts();
        for (int i = 0; i < 4096; i++) trans_counts[i] = '0;
        for (int i = 0; i < 2048; i++) emit_counts[i] = '0;
        prev_label = '0;
    endtask

    // Predict the updates of one sequence position in the order they leave
    task automatic add_position(input logic [4:0] sym, input logic [5:0] lab,
                                input logic [15:0] w, input logic first,
                                input logic last);
        logic [5:0] from;
        logic [5:0] end_st;
        int         idx;
        from   = first ? 6'(hca_pkg::START_ST) : prev_label;
        end_st = 6'(hca_pkg::END_ST);
        idx = int'({from, lab});
        trans_counts[idx] = sat_sum(trans_counts[idx], w);
        upcoming_updates.push_back('{hca_pkg::KIND_TRANS, from, lab,
                                     trans_counts[idx], 1'b0});
        idx = int'({sym, lab});
        emit_counts[idx] = sat_sum(emit_counts[idx], w);
        upcoming_updates.push_back('{hca_pkg::KIND_EMIT, 6'(sym), lab,
                                     emit_counts[idx], !last});
        if (last) begin
            idx = int'({lab, end_st});
            trans_counts[idx] = sat_sum(trans_counts[idx], w);
            upcoming_updates.push_back('{hca_pkg::KIND_TRANS, lab, end_st,
                                         trans_counts[idx], 1'b1});
        end
        prev_label = lab;
    endtask

    task automatic report(input string what, input t_count_update got,
                          input t_count_update want);
        $display("%0t ns count check: %s: got kind %0d row %0d col %0d count 0x%08h fin %0b,",
                 $time, what, got.kind, got.row, got.col, got.count, got.fin,
                 " want kind %0d row %0d col %0d count 0x%08h fin %0b",
                 want.kind, want.row, want.col, want.count, want.fin);
        err_cnt++;
    endtask

    initial begin
        err_cnt     = 0;
        checked_cnt = 0;
    end

    always @(posedge i_clk) begin : watch
        t_count_update got;
        t_count_update want;
        string         diffs;
        if (!i_rst_n) begin
            zero_shadow_counts();
            upcoming_updates.delete();
        end else begin
            // Compare a returned update with the oldest prediction
            if (i_res_valid === 1'b1 && i_res_ready === 1'b1) begin
                got = '{i_kind, i_row_index, i_col_index, i_count_value, i_final_result};
                checked_cnt++;
                if (upcoming_updates.size() == 0) begin
                    report("update with nothing outstanding", got, '0);
                end else begin
                    want  = upcoming_updates.pop_front();
                    diffs = "";
                    if (got.kind  !== want.kind)  diffs = {diffs, " kind"};
                    if (got.row   !== want.row)   diffs = {diffs, " row"};
                    if (got.col   !== want.col)   diffs = {diffs, " col"};
                    if (got.count !== want.count) diffs = {diffs, " count"};
                    if (got.fin   !== want.fin)   diffs = {diffs, " final"};
                    if (diffs != "") report({"wrong", diffs}, got, want);
                end
            end
            // Predict the updates of an accepted request
            if (i_req_valid === 1'b1 && i_req_ready === 1'b1) begin
                if (i_cmd == hca_pkg::CMD_CLEAR) begin
                    zero_shadow_counts();
                    upcoming_updates.push_back('{hca_pkg::KIND_CLEAR, 6'd0, 6'd0,
                                                 32'd0, 1'b1});
                end else begin
                    add_position(i_symbol, i_label, i_weight, i_first_pos, i_last_pos);
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= upcoming_updates.size();
        o_checked <= checked_cnt;
    end

endmodule

[bench/hmm_count_accumulator_tb.sv]
// Testbench top for the HMM count accumulator: clock, reset, request stimulus
// and receiver stalls; checking is done by hca_count_checker.
// Depends on hca_pkg, hca_count_checker and the hmm_count_accumulator RTL.
module hmm_count_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ACCUM        = hca_pkg::CMD_ACCUM;
    localparam logic CMD_CLEAR        = hca_pkg::CMD_CLEAR;
    localparam int   CYCLE_LIMIT      = 2_000_000;
    localparam int   RANDOM_POSITIONS = 430;
    localparam int   RANDOM_CLEARS    = 2;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_cmd       = 1'b0;
    logic [4:0]  i_symbol    = '0;
    logic [5:0]  i_label     = '0;
    logic [15:0] i_weight    = '0;
    logic        i_first_pos = 1'b0;
    logic        i_last_pos  = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [5:0]  o_row_index;
    logic [5:0]  o_col_index;
    logic [31:0] o_count_value;
    logic        o_final_result;

    int errors;
    int pending;
    int checked;
    int cycle_cnt   = 0;
    int rx_stall    = 0;
    bit rx_no_idle  = 1'b0;
    bit tx_no_idle  = 1'b0;
    int pos_sent    = 0;
    int clears_sent = 0;
    int seq_cnt     = 0;

    hmm_count_accumulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_symbol       (i_symbol),
        .i_label        (i_label),
        .i_weight       (i_weight),
        .i_first_pos    (i_first_pos),
        .i_last_pos     (i_last_pos),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_count_value  (o_count_value),
        .o_final_result (o_final_result)
    );

    hca_count_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_cmd          (i_cmd),
        .i_symbol       (i_symbol),
        .i_label        (i_label),
        .i_weight       (i_weight),
        .i_first_pos    (i_first_pos),
        .i_last_pos     (i_last_pos),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_kind         (o_kind),
        .i_row_index    (o_row_index),
        .i_col_index    (o_col_index),
        .i_count_value  (o_count_value),
        .i_final_result (o_final_result),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Favor the start and end labels and a few reused cells
    function automatic logic [5:0] pick_label();
        if ($urandom_range(0, 99) < 35) return 6'($urandom_range(0, 3));
        return 6'($urandom);
    endfunction

    function automatic logic [15:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'hFFFF;
        if (r < 14) return 16'h0000;
        if (r < 22) return 16'($urandom_range(1, 3));
        if (r < 30) return 16'h0100;
        return 16'($urandom);
    endfunction

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d updates outstanding", cycle_cnt, pending);
            $display("hmm_count_accumulator: mismatch");
            $finish;
        end
    end

    // Receiver: stall at random unless a no-idle stretch is on
    always @(posedge i_clk) begin
        if (rx_no_idle) begin
            rx_stall = 0;
            i_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            rx_stall = idle_cycles();
            i_ready <= (rx_stall == 0);
            if (rx_stall > 0) rx_stall--;
        end
    end

    // Present one request and hold it until it is taken; valid stays high after
    task automatic send_req(input logic cmd, input logic [4:0] sym,
                            input logic [5:0] lab, input logic [15:0] w,
                            input logic first, input logic last);
        int gap;
        gap = tx_no_idle ? 0 : idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_symbol    <= sym;
        i_label     <= lab;
        i_weight    <= w;
        i_first_pos <= first;
        i_last_pos  <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (cmd == CMD_CLEAR) clears_sent++;
        else pos_sent++;
    endtask

    // Drop valid and hold off until every predicted update has come back
    task automatic wait_counts_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One sequence under one weight; optionally scramble the marks or drop the first mark
    task automatic send_sequence(input int len, input bit flag_noise,
                                 input bit drop_first);
        logic [15:0] w;
        logic        f;
        logic        l;
        w = pick_weight();
        for (int i = 0; i < len; i++) begin
            f = (i == 0) && !drop_first;
            l = (i == len - 1);
            if (flag_noise) begin
                f = 1'($urandom);
                l = 1'($urandom);
            end
            send_req(CMD_ACCUM, 5'($urandom), pick_label(), w, f, l);
        end
        seq_cnt++;
    endtask

    initial begin : stimulus
        int  start_pos;
        int  r;
        bit  burst;
        int  rand_clears;
        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners
        // no first mark right after reset: comes from the start state
        send_req(CMD_ACCUM, 5'd4, 6'd5, 16'h0100, 1'b0, 1'b0);
        send_req(CMD_ACCUM, 5'd31, 6'd0, 16'hFFFF, 1'b1, 1'b0);
        // labels equal to the end state, zero weight
        send_req(CMD_ACCUM, 5'd0, 6'd1, 16'h0000, 1'b0, 1'b0);
        // 1 -> 1 then 1 -> end hits the same cell twice in one request
        send_req(CMD_ACCUM, 5'd17, 6'd1, 16'h8001, 1'b0, 1'b1);
        send_req(CMD_ACCUM, 5'd31, 6'd63, 16'hFFFF, 1'b1, 1'b1);
        send_req(CMD_ACCUM, 5'd0, 6'd63, 16'h0001, 1'b1, 1'b0);
        send_req(CMD_ACCUM, 5'd10, 6'd63, 16'h7FFF, 1'b0, 1'b0);
        send_req(CMD_ACCUM, 5'd21, 6'd42, 16'hAAAA, 1'b0, 1'b0);
        send_req(CMD_ACCUM, 5'd10, 6'd21, 16'h5555, 1'b0, 1'b1);
        // clear with every other field high; the next one restarts from zero
        send_req(CMD_CLEAR, 5'd31, 6'd63, 16'hFFFF, 1'b1, 1'b1);
        send_req(CMD_ACCUM, 5'd31, 6'd63, 16'hFFFF, 1'b0, 1'b1);
        send_req(CMD_ACCUM, 5'd0, 6'd0, 16'h0000, 1'b1, 1'b1);
        send_req(CMD_ACCUM, 5'd31, 6'd0, 16'h00FF, 1'b0, 1'b0);
        send_req(CMD_CLEAR, 5'd0, 6'd0, 16'h0000, 1'b0, 1'b0);
        send_req(CMD_ACCUM, 5'd3, 6'd2, 16'h1234, 1'b0, 1'b0);
        send_req(CMD_ACCUM, 5'd3, 6'd2, 16'hFF00, 1'b0, 1'b1);
        wait_counts_drained();

        // Random sequences, mostly well formed
        start_pos   = pos_sent;
        rand_clears = 0;
        while (pos_sent - start_pos < RANDOM_POSITIONS) begin
            burst       = ($urandom_range(0, 99) < 15);
            tx_no_idle  = burst;
            rx_no_idle <= burst;
            r = $urandom_range(0, 99);
            if (r < 80) begin
                send_sequence($urandom_range(1, 8), 1'b0, 1'b0);
            end else if (r < 90) begin
                send_sequence($urandom_range(1, 6), 1'b1, 1'b0);
            end else if (r < 97 || rand_clears >= RANDOM_CLEARS) begin
                send_sequence($urandom_range(1, 6), 1'b0, 1'b1);
            end else begin
                send_req(CMD_CLEAR, 5'($urandom), 6'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom));
                rand_clears++;
            end
            if ($urandom_range(0, 9) == 0) wait_counts_drained();
        end
        wait_counts_drained();

        // Clear once more and accumulate onto the zeroed stores
        tx_no_idle  = 1'b0;
        rx_no_idle <= 1'b0;
        send_req(CMD_CLEAR, 5'd0, 6'd0, 16'h0000, 1'b0, 1'b0);
        send_req(CMD_ACCUM, 5'd9, 6'd3, 16'h0001, 1'b0, 1'b1);

        // Drain, then let any stray update show up
        wait_counts_drained();
        repeat (20) @(posedge i_clk);

        $display("run: %0d positions over %0d random sequences and directed corners, %0d clears",
                 pos_sent, seq_cnt, clears_sent);
        $display("run: %0d count updates compared under receiver stalls and drain pauses",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("hmm_count_accumulator: match");
        end else begin
            $display("hmm_count_accumulator: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
hdl/hca_pkg.sv
hdl/hca_count_ram.sv
hdl/hca_sat_add.sv
hdl/hmm_count_accumulator.sv
bench/hca_count_checker.sv
bench/hmm_count_accumulator_tb.sv
